>>> sv/aalr_pkg.sv
// aalr_pkg: shared types and constants for the anti-aliased line rasterizer.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package aalr_pkg;
  localparam int COORD_BITS_DEF = 10;
  localparam int CB = 10;
  localparam logic [15:0] GREEN_MASK = 16'h07E0;
  localparam logic [15:0] BLUE_MASK  = 16'h001F;
  localparam logic [5:0]  MAX5 = 6'd31;
  localparam logic [5:0]  MAX6 = 6'd63;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic          command;
    logic [CB-1:0] start_x;
    logic [CB-1:0] start_y;
    logic [CB-1:0] end_col;
    logic [CB-1:0] end_row;
    logic [15:0]   line_color;
  } in_req_t;

  typedef struct packed {
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic [15:0]   pixel_color;
    logic          last_of_step;
    logic          line_done;
  } out_req_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // latch a start request
    logic sqrt_go;   // start the edge length root
    logic pix_go;    // compute next pixel of current step
    logic commit;    // apply step state update
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic busy;      // root or divider running
    logic pix_valid; // a pixel finished
    logic step_end;  // the finished pixel is the last of the step
  } dp_sts_t;
endpackage

>>> sv/aalr_datapath.sv
// aalr_datapath: line state, integer square root and shared serial divider for blending.
// Depends on aalr_pkg.
`timescale 1ns / 1ps
module aalr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  aalr_pkg::in_req_t   req,
  input  aalr_pkg::dp_cmd_t   cmd,
  output aalr_pkg::dp_sts_t   sts,
  output aalr_pkg::out_req_t  pix,
  output logic                active
);
  localparam int CB = aalr_pkg::CB;
  localparam int EW = CB + 2;          // signed error width
  localparam int LW = CB + 1;          // edge length width
  localparam int SQW = 2 * CB + 2;     // squared sum width (even)
  localparam int NR = SQW / 2;         // root iterations
  localparam int NW = EW + 1;          // weight arithmetic width
  localparam int PW = 6 + LW;          // product width

  logic [CB-1:0] cur_x_r, cur_y_r, tx_r, ty_r, dx_r, dy_r;
  logic          nx_r, ny_r, active_r;
  logic signed [EW-1:0] err_r;
  logic [LW-1:0] ed_r;
  logic [15:0]   col_r;

  // sqrt state
  logic [SQW-1:0] sq_v_r, sq_res_r, sq_bit_r;
  logic           sq_busy_r;
  logic [$clog2(NR+1)-1:0] sq_cnt_r;
  logic           zero_len_r;

  // step sequencing: pixel index 0 main, 1 first side, 2 second side
  logic [1:0] pidx_r;
  // divider
  logic           dv_busy_r;
  logic [1:0]     dv_ch_r;
  logic [PW-1:0]  dv_rem_r, dv_num_r;
  logic [4:0]     dv_q_r;
  logic [$clog2(PW+1)-1:0] dv_cnt_r;
  logic [LW-1:0]  w_r;
  logic [4:0]     rr_r, bb_r;
  logic [5:0]     gg_r;
  logic [CB-1:0]  px_r, py_r;
  logic           last_r, done_r, pv_r;

  // step decisions, combinational from state
  logic signed [NW-1:0] e2, sdx, sdy, n0, n1, n2;
  logic c1, c2, at_x, at_y, e1ok, e2ok, take1, take2, end1, done_s;
  always_comb begin
    e2  = NW'(err_r);
    sdx = NW'(signed'({1'b0, dx_r}));
    sdy = NW'(signed'({1'b0, dy_r}));
    n0  = e2 - sdx + sdy;
    if (n0 < 0) n0 = -n0;
    n1  = e2 + sdy;
    n2  = sdx - e2;
    c1  = (e2 <<< 1) >= -sdx;
    c2  = (e2 <<< 1) <= sdy;
    at_x = cur_x_r == tx_r;
    at_y = cur_y_r == ty_r;
    e1ok = n1 < NW'(signed'({1'b0, ed_r}));
    e2ok = n2 < NW'(signed'({1'b0, ed_r}));
    done_s = (c1 && at_x) || (!(c1 && at_x) && c2 && at_y);
    take1 = c1 && !at_x && e1ok;
    take2 = !(c1 && at_x) && c2 && !at_y && e2ok;
    end1 = !take2;
  end

  logic signed [NW-1:0] nsel;
  logic [CB-1:0] sx_nx, sy_nx;
  always_comb begin
    sx_nx = nx_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    sy_nx = ny_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    nsel = n0;
    priority if (pidx_r == 2'd0) nsel = n0;
    else if (pidx_r == 2'd1 && take1) nsel = n1;
    else nsel = n2;
  end

  logic [LW-1:0] wclamp;
  always_comb begin
    if (nsel < 0) wclamp = '0;
    else if (nsel > NW'(signed'({1'b0, ed_r}))) wclamp = ed_r;
    else wclamp = nsel[LW-1:0];
  end

  logic [5:0] ch_c, ch_max;
  always_comb begin
    unique case (dv_ch_r)
      2'd0: begin ch_c = {1'b0, col_r[15:11]}; ch_max = aalr_pkg::MAX5; end
      2'd1: begin ch_c = 6'((col_r & aalr_pkg::GREEN_MASK) >> 5); ch_max = aalr_pkg::MAX6; end
      default: begin ch_c = 6'(col_r & aalr_pkg::BLUE_MASK); ch_max = aalr_pkg::MAX5; end
    endcase
  end

  logic [PW-1:0] rem_sh;
  logic [PW:0]   rem_try;
  always_comb begin
    rem_sh  = {dv_rem_r[PW-2:0], dv_num_r[PW-1]};
    rem_try = {1'b0, rem_sh} - {{(PW-LW+1){1'b0}}, ed_r};
  end

  logic [SQW-1:0] sq_sum;
  logic [CB-1:0] adx, ady;
  logic [SQW-1:0] sq_try;
  always_comb begin
    adx = (req.end_col > req.start_x) ? req.end_col - req.start_x : req.start_x - req.end_col;
    ady = (req.end_row > req.start_y) ? req.end_row - req.start_y : req.start_y - req.end_row;
    sq_sum = SQW'(dx_r) * SQW'(dx_r) + SQW'(dy_r) * SQW'(dy_r);
    sq_try = sq_res_r + sq_bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0; cur_y_r <= '0; tx_r <= '0; ty_r <= '0;
      dx_r <= '0; dy_r <= '0; nx_r <= 1'b0; ny_r <= 1'b0;
      err_r <= '0; ed_r <= LW'(1); col_r <= '0; active_r <= 1'b0;
      sq_busy_r <= 1'b0; dv_busy_r <= 1'b0; pv_r <= 1'b0; pidx_r <= '0;
      sq_cnt_r <= '0; zero_len_r <= 1'b0; dv_ch_r <= '0;
    end else begin
      pv_r <= 1'b0;
      if (cmd.load) begin
        cur_x_r <= req.start_x; cur_y_r <= req.start_y;
        tx_r <= req.end_col; ty_r <= req.end_row;
        col_r <= req.line_color;
        dx_r <= adx; dy_r <= ady;
        nx_r <= !(req.start_x < req.end_col);
        ny_r <= !(req.start_y < req.end_row);
        err_r <= EW'(signed'({1'b0, adx})) - EW'(signed'({1'b0, ady}));
        active_r <= 1'b1;
        pidx_r <= '0;
      end
      if (cmd.sqrt_go) begin
        sq_v_r <= sq_sum; sq_res_r <= '0;
        sq_bit_r <= SQW'(1) << (SQW - 2);
        sq_cnt_r <= '0; sq_busy_r <= 1'b1;
        zero_len_r <= (dx_r == '0) && (dy_r == '0);
      end else if (sq_busy_r) begin
        if (sq_v_r >= sq_try) begin
          sq_v_r <= sq_v_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else sq_res_r <= sq_res_r >> 1;
        sq_bit_r <= sq_bit_r >> 2;
        sq_cnt_r <= sq_cnt_r + 1'b1;
        if (sq_cnt_r == ($clog2(NR+1))'(NR - 1)) begin
          sq_busy_r <= 1'b0;
          if (zero_len_r) ed_r <= LW'(1);
          else if (sq_v_r >= sq_try) ed_r <= LW'((sq_res_r >> 1) + sq_bit_r);
          else ed_r <= LW'(sq_res_r >> 1);
        end
      end
      if (cmd.pix_go) begin
        w_r <= wclamp;
        dv_ch_r <= 2'd0; dv_busy_r <= 1'b1; dv_cnt_r <= '0;
        dv_rem_r <= '0; dv_q_r <= '0;
        dv_num_r <= PW'((aalr_pkg::MAX5 - {1'b0, col_r[15:11]}) * wclamp);
        priority if (pidx_r == 2'd0) begin
          px_r <= cur_x_r; py_r <= cur_y_r;
          last_r <= !(take1 || take2); done_r <= done_s && !(take1 || take2);
        end else if (pidx_r == 2'd1 && take1) begin
          px_r <= cur_x_r; py_r <= sy_nx;
          last_r <= end1; done_r <= done_s && end1;
        end else begin
          px_r <= sx_nx; py_r <= cur_y_r;
          last_r <= 1'b1; done_r <= done_s;
        end
      end else if (dv_busy_r) begin
        dv_num_r <= dv_num_r << 1;
        if (!rem_try[PW]) begin
          dv_rem_r <= rem_try[PW-1:0]; dv_q_r <= {dv_q_r[3:0], 1'b1};
        end else begin
          dv_rem_r <= rem_sh; dv_q_r <= {dv_q_r[3:0], 1'b0};
        end
        dv_cnt_r <= dv_cnt_r + 1'b1;
        if (dv_cnt_r == ($clog2(PW+1))'(PW - 1)) begin
          dv_cnt_r <= '0; dv_rem_r <= '0; dv_q_r <= '0;
          unique case (dv_ch_r)
            2'd0: begin
              rr_r <= 5'(ch_c + {dv_q_r, !rem_try[PW]});
              dv_ch_r <= 2'd1;
              dv_num_r <= PW'((aalr_pkg::MAX6 - 6'((col_r & aalr_pkg::GREEN_MASK) >> 5)) * w_r);
            end
            2'd1: begin
              gg_r <= 6'(ch_c + {dv_q_r, !rem_try[PW]});
              dv_ch_r <= 2'd2;
              dv_num_r <= PW'((aalr_pkg::MAX5 - 6'(col_r & aalr_pkg::BLUE_MASK)) * w_r);
            end
            default: begin
              bb_r <= 5'(ch_c + {dv_q_r, !rem_try[PW]});
              dv_busy_r <= 1'b0; pv_r <= 1'b1;
              pidx_r <= (pidx_r == 2'd0) ? (take1 ? 2'd1 : 2'd2) : 2'd2;
            end
          endcase
        end
      end
      if (cmd.commit) begin
        pidx_r <= '0;
        if (done_s) active_r <= 1'b0;
        else begin
          err_r <= err_r - (c1 ? EW'(signed'({1'b0, dy_r})) : EW'(0))
                         + (c2 ? EW'(signed'({1'b0, dx_r})) : EW'(0));
          if (c1) cur_x_r <= sx_nx;
          if (c2) cur_y_r <= sy_nx;
        end
      end
    end
  end

  assign sts.busy      = sq_busy_r || dv_busy_r;
  assign sts.pix_valid = pv_r;
  assign sts.step_end  = last_r;
  assign active        = active_r;
  assign pix = '{pixel_x: px_r, pixel_y: py_r, pixel_color: {rr_r, gg_r, bb_r},
                 last_of_step: last_r, line_done: done_r};

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n) !(sq_busy_r && dv_busy_r))
    else $error("root and divider both busy");
  a_ed_nz: assert property (@(posedge clk) disable iff (!rst_n) ed_r != '0)
    else $error("edge length zero");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n) pv_r && done_r |-> last_r)
    else $error("line_done without last_of_step");
`endif
endmodule

>>> sv/aalr_ctrl.sv
// aalr_ctrl: request sequencing state machine for the rasterizer.
// Depends on aalr_pkg.
`timescale 1ns / 1ps
module aalr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  input  logic               line_active,
  input  aalr_pkg::dp_sts_t  sts,
  output aalr_pkg::dp_cmd_t  cmd,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_capture
);
  typedef enum logic [2:0] {S_IDLE, S_ROOT, S_ROOTW, S_PIX, S_WAIT, S_SEND} state_t;
  state_t state_r, state_nxt;
  logic ov_r, ov_nxt, lastp_r, lastp_nxt;
  logic acc;

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign acc = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; ov_nxt = ov_r; lastp_nxt = lastp_r;
    cmd = '0; out_capture = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (acc) begin
        if (in_cmd == aalr_pkg::CMD_START) begin
          cmd.load = 1'b1; state_nxt = S_ROOT;
        end else if (line_active) state_nxt = S_PIX;
      end
      S_ROOT:  begin cmd.sqrt_go = 1'b1; state_nxt = S_ROOTW; end
      S_ROOTW: if (!sts.busy) state_nxt = S_IDLE;
      S_PIX:   if (!ov_r) begin cmd.pix_go = 1'b1; state_nxt = S_WAIT; end
      S_WAIT:  if (sts.pix_valid) state_nxt = S_SEND;
      S_SEND: if (!ov_nxt) begin
        out_capture = 1'b1; ov_nxt = 1'b1; lastp_nxt = sts.step_end;
        if (sts.step_end) begin cmd.commit = 1'b1; state_nxt = S_IDLE; end
        else state_nxt = S_PIX;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; lastp_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; lastp_r <= lastp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  a_cap_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_capture |-> !(ov_r && out_stall)) else $error("overwrite of held result");
  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid && lastp_r) else $error("commit without last pixel");
`endif
endmodule

>>> sv/antialiased_line_rasterizer.sv
// antialiased_line_rasterizer: top level, controller plus datapath plus output register.
// Depends on aalr_pkg, aalr_ctrl, aalr_datapath.
`timescale 1ns / 1ps
// channel | ports                       | direction | moves
// input   | in_valid, in_stall, in_data | in        | start or step request
// output  | out_valid, out_stall, out_data | out    | one pixel request
// Start: the edge length comes from a bit-serial square root of CB+1 iterations.
// Step: per pixel, three channel divisions on one serial divider.
// Reset (rst_n low, synchronous) idles the block; edge length reads 1.
// Input is stalled while a request is in work or a result is held.
// A held result waits for out_stall low; the next pixel starts only then.
module antialiased_line_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aalr_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aalr_pkg::out_req_t out_data
);
  aalr_pkg::dp_cmd_t  cmd;
  aalr_pkg::dp_sts_t  sts;
  aalr_pkg::out_req_t pix;
  aalr_pkg::out_req_t out_r;
  logic line_active, cap;

  aalr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_data.command),
    .in_stall(in_stall), .line_active(line_active), .sts(sts), .cmd(cmd),
    .out_stall(out_stall), .out_valid(out_valid), .out_capture(cap)
  );

  aalr_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts),
    .pix(pix), .active(line_active)
  );

  // output register: payload, no reset needed
  always_ff @(posedge clk) begin
    if (cap) out_r <= pix;
  end
  assign out_data = out_r;
endmodule

>>> dv/antialiased_line_rasterizer_tb.sv
// antialiased_line_rasterizer_tb: self-checking bench for the anti-aliased line rasterizer.
// Depends on aalr_pkg and antialiased_line_rasterizer; predicts each pixel request in-bench.
`timescale 1ns / 1ps
module antialiased_line_rasterizer_tb;

  localparam int LIMIT_CYCLES = 1500000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  aalr_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  aalr_pkg::out_req_t out_data;

  antialiased_line_rasterizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state, mirrors the rasterizer's line registers.
  int   ln_x, ln_y, ln_tx, ln_ty, ln_dx, ln_dy, ln_err, ln_ed;
  logic ln_negx, ln_negy, ln_active;
  logic [15:0] ln_color;

  aalr_pkg::out_req_t pixel_queue[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   idle_enable = 1'b1;   // random gaps on both sides
  bit   hold_off = 1'b0;      // long receiver stall

  function automatic int root_floor(longint v);
    longint r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return int'(r);
  endfunction

  function automatic logic [15:0] shade(int n);
    int w, r, g, b;
    w = (n < 0) ? 0 : (n > ln_ed ? ln_ed : n);
    r = int'(ln_color[15:11]);
    g = int'(ln_color[10:5]);
    b = int'(ln_color[4:0]);
    r = r + ((31 - r) * w) / ln_ed;
    g = g + ((63 - g) * w) / ln_ed;
    b = b + ((31 - b) * w) / ln_ed;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic void push_pixel(int x, int y, int n);
    aalr_pkg::out_req_t p;
    p.pixel_x = x[aalr_pkg::CB-1:0];
    p.pixel_y = y[aalr_pkg::CB-1:0];
    p.pixel_color = shade(n);
    p.last_of_step = 1'b0;
    p.line_done = 1'b0;
    pixel_queue.push_back(p);
  endfunction

  // Advance the line model by one request, queue the pixels it yields.
  function automatic void predict_line(aalr_pkg::in_req_t r);
    int e2, x2, sx, sy, n;
    bit done, any;
    if (r.command == aalr_pkg::CMD_START) begin
      ln_x = int'(r.start_x); ln_y = int'(r.start_y);
      ln_tx = int'(r.end_col); ln_ty = int'(r.end_row);
      ln_color = r.line_color;
      ln_dx = (ln_tx > ln_x) ? ln_tx - ln_x : ln_x - ln_tx;
      ln_dy = (ln_ty > ln_y) ? ln_ty - ln_y : ln_y - ln_ty;
      ln_negx = !(ln_x < ln_tx);
      ln_negy = !(ln_y < ln_ty);
      ln_err = ln_dx - ln_dy;
      ln_ed = (ln_dx + ln_dy == 0) ? 1 : root_floor(longint'(ln_dx) * ln_dx
                                                    + longint'(ln_dy) * ln_dy);
      ln_active = 1'b1;
      return;
    end
    if (!ln_active) return;
    sx = ln_negx ? -1 : 1;
    sy = ln_negy ? -1 : 1;
    done = 1'b0;
    n = ln_err - ln_dx + ln_dy;
    if (n < 0) n = -n;
    push_pixel(ln_x, ln_y, n);
    e2 = ln_err;
    x2 = ln_x;
    if (2 * e2 >= -ln_dx) begin
      if (ln_x == ln_tx) done = 1'b1;
      else begin
        if (e2 + ln_dy < ln_ed) push_pixel(ln_x, ln_y + sy, e2 + ln_dy);
        ln_err -= ln_dy;
        ln_x = (ln_x + sx) & 10'h3FF;
      end
    end
    if (!done && 2 * e2 <= ln_dy) begin
      if (ln_y == ln_ty) done = 1'b1;
      else begin
        if (ln_dx - e2 < ln_ed) push_pixel(x2 + sx, ln_y, ln_dx - e2);
        ln_err += ln_dx;
        ln_y = (ln_y + sy) & 10'h3FF;
      end
    end
    any = 1'b1;
    pixel_queue[$].last_of_step = any;
    if (done) begin
      pixel_queue[$].line_done = 1'b1;
      ln_active = 1'b0;
    end
  endfunction

  // Offer one request, hold it until accepted; the model steps on acceptance.
  task automatic send_request(aalr_pkg::in_req_t r);
    while (idle_enable && $urandom_range(99) < 28) @(negedge clk);
    in_data = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_line(r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic start_line(int x0, int y0, int x1, int y1, int c);
    aalr_pkg::in_req_t r;
    r.command = aalr_pkg::CMD_START;
    r.start_x = x0[aalr_pkg::CB-1:0]; r.start_y = y0[aalr_pkg::CB-1:0];
    r.end_col = x1[aalr_pkg::CB-1:0]; r.end_row = y1[aalr_pkg::CB-1:0];
    r.line_color = c[15:0];
    send_request(r);
  endtask

  // Steps carry random junk in the unused fields.
  task automatic step_line(int count);
    aalr_pkg::in_req_t r;
    logic [63:0] junk;
    repeat (count) begin
      junk = {$urandom, $urandom};
      r = junk[$bits(aalr_pkg::in_req_t)-1:0];
      r.command = aalr_pkg::CMD_STEP;
      send_request(r);
    end
  endtask

  // Receiver: random stalls, or a long hold when asked.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= idle_enable && ($urandom_range(99) < 28);
  end

  // Pixel checker, samples at the rising edge.
  always @(posedge clk) begin
    aalr_pkg::out_req_t want;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d", out_data.pixel_x, out_data.pixel_y);
          fail_count++;
        end else begin
          want = pixel_queue.pop_front();
          if (out_data.pixel_x !== want.pixel_x) begin
            $error("pixel_x exp %0d got %0d", want.pixel_x, out_data.pixel_x);
            fail_count++;
          end
          if (out_data.pixel_y !== want.pixel_y) begin
            $error("pixel_y exp %0d got %0d", want.pixel_y, out_data.pixel_y);
            fail_count++;
          end
          if (out_data.pixel_color !== want.pixel_color) begin
            $error("pixel_color exp %h got %h", want.pixel_color, out_data.pixel_color);
            fail_count++;
          end
          if (out_data.last_of_step !== want.last_of_step) begin
            $error("last_of_step exp %b got %b", want.last_of_step, out_data.last_of_step);
            fail_count++;
          end
          if (out_data.line_done !== want.line_done) begin
            $error("line_done exp %b got %b", want.line_done, out_data.line_done);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed: step while idle, zero length, extremes of the grid and color, abandon.
  task automatic test_directed();
    step_line(1);
    start_line(5, 5, 5, 5, 16'hF81F);
    step_line(2);
    start_line(0, 0, 1023, 1023, 16'h0000);
    step_line(4);
    start_line(1023, 0, 0, 1023, 16'hFFFF);
    step_line(3);
    start_line(0, 1023, 3, 0, 16'h07E0);
    step_line(3);
    start_line(10, 20, 14, 22, 16'h001F);
    step_line(7);
  endtask

  // Random short lines stepped a random number of times, some abandoned; every fifth is oversized.
  task automatic test_random_lines();
    int x0, y0, len;
    for (int i = 0; i < 12; i++) begin
      if (i == 6) idle_enable = 1'b0;
      if (i == 9) idle_enable = 1'b1;
      x0 = $urandom_range(1023);
      y0 = $urandom_range(1023);
      len = (i % 5 == 4) ? 1023 : 6;
      start_line(x0, y0, (x0 + $urandom_range(2 * len) - len) & 10'h3FF,
                 (y0 + $urandom_range(2 * len) - len) & 10'h3FF, $urandom);
      step_line((i % 5 == 4) ? 3 : $urandom_range(3, 9));
    end
  endtask

  // Receiver holds off while the sender keeps pushing steps.
  task automatic test_backpressure();
    int hold_cycles;
    start_line(100, 100, 120, 108, 16'h8410);
    hold_off = 1'b1;
    fork
      step_line(6);
      begin
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_lines();
    test_backpressure();
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pixel_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
sv/aalr_pkg.sv
sv/aalr_datapath.sv
sv/aalr_ctrl.sv
sv/antialiased_line_rasterizer.sv
dv/antialiased_line_rasterizer_tb.sv
